@@ design/mld_pkg.sv @@
// shared types, constants and the arctangent table for the mouse-look block
`timescale 1ns / 1ps
`default_nettype none

package mld_pkg;

  // default build values
  localparam int DEF_CORDIC_ITERATIONS = 16;
  localparam int DEF_ANGLE_FRAC_BITS   = 16;
  localparam int MAX_ITERATIONS        = 24;

  // register reset values
  localparam logic [15:0] SENS_RESET = 16'd13107;
  localparam logic [6:0]  PLIM_RESET = 7'd89;
  localparam logic [6:0]  PLIM_MAX   = 7'd89;

  // register byte addresses
  localparam logic [2:0] ADDR_SENS = 3'd0;
  localparam logic [2:0] ADDR_PLIM = 3'd4;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MULX,
    OP_YAW,
    OP_PITCH,
    OP_MOD,
    OP_ZYAW,
    OP_ROT,
    OP_ZPITCH,
    OP_SAVEP,
    OP_MULC,
    OP_MULS,
    OP_OUT
  } mld_op_e;

  typedef struct packed {
    mld_op_e    op;
    logic [4:0] idx;
  } mld_cmd_t;

  // atan(2^-i) in degrees, Q.16
  function automatic logic [21:0] atan_q16(input logic [4:0] i);
    logic [21:0] r;
    case (i)
      5'd0:    r = 22'd2949120;
      5'd1:    r = 22'd1740967;
      5'd2:    r = 22'd919879;
      5'd3:    r = 22'd466945;
      5'd4:    r = 22'd234379;
      5'd5:    r = 22'd117304;
      5'd6:    r = 22'd58666;
      5'd7:    r = 22'd29335;
      5'd8:    r = 22'd14668;
      5'd9:    r = 22'd7334;
      5'd10:   r = 22'd3667;
      5'd11:   r = 22'd1833;
      5'd12:   r = 22'd917;
      5'd13:   r = 22'd458;
      5'd14:   r = 22'd229;
      5'd15:   r = 22'd115;
      5'd16:   r = 22'd57;
      5'd17:   r = 22'd29;
      5'd18:   r = 22'd14;
      5'd19:   r = 22'd7;
      5'd20:   r = 22'd4;
      5'd21:   r = 22'd2;
      5'd22:   r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/mld_ctrl.sv @@
// controller state machine: sequences the datapath and runs both handshakes
`timescale 1ns / 1ps
`default_nettype none

module mld_ctrl #(
  parameter int CORDIC_ITERATIONS = mld_pkg::DEF_CORDIC_ITERATIONS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output mld_pkg::mld_cmd_t     cmd_o
);

  localparam int NITER = (CORDIC_ITERATIONS > mld_pkg::MAX_ITERATIONS) ?
                         mld_pkg::MAX_ITERATIONS : CORDIC_ITERATIONS;
  localparam logic [4:0] LAST_ITER = 5'(NITER - 1);
  localparam logic [4:0] MOD_TOP   = 5'd8;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MULX  = 4'd1;
  localparam logic [3:0] ST_YAW   = 4'd2;
  localparam logic [3:0] ST_PITCH = 4'd3;
  localparam logic [3:0] ST_MOD   = 4'd4;
  localparam logic [3:0] ST_ZYAW  = 4'd5;
  localparam logic [3:0] ST_ROTY  = 4'd6;
  localparam logic [3:0] ST_ZP    = 4'd7;
  localparam logic [3:0] ST_ROTP  = 4'd8;
  localparam logic [3:0] ST_SAVEP = 4'd9;
  localparam logic [3:0] ST_MULC  = 4'd10;
  localparam logic [3:0] ST_MULS  = 4'd11;
  localparam logic [3:0] ST_OUT   = 4'd12;

  logic [3:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       oval_q, oval_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = oval_q;

  // next state, step counter and datapath command
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    oval_d    = oval_q;
    cmd_o.op  = mld_pkg::OP_NOP;
    cmd_o.idx = cnt_q;
    if (oval_q && out_ready_i) begin
      oval_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = mld_pkg::OP_LOAD;
          state_d  = ST_MULX;
        end
      end
      ST_MULX: begin
        cmd_o.op = mld_pkg::OP_MULX;
        state_d  = ST_YAW;
      end
      ST_YAW: begin
        cmd_o.op = mld_pkg::OP_YAW;
        state_d  = ST_PITCH;
      end
      ST_PITCH: begin
        cmd_o.op = mld_pkg::OP_PITCH;
        cnt_d    = MOD_TOP;
        state_d  = ST_MOD;
      end
      ST_MOD: begin
        cmd_o.op = mld_pkg::OP_MOD;
        if (cnt_q == '0) begin
          state_d = ST_ZYAW;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      ST_ZYAW: begin
        cmd_o.op = mld_pkg::OP_ZYAW;
        cnt_d    = '0;
        state_d  = ST_ROTY;
      end
      ST_ROTY: begin
        cmd_o.op = mld_pkg::OP_ROT;
        if (cnt_q == LAST_ITER) begin
          cnt_d   = '0;
          state_d = ST_ZP;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_ZP: begin
        cmd_o.op = mld_pkg::OP_ZPITCH;
        state_d  = ST_ROTP;
      end
      ST_ROTP: begin
        cmd_o.op = mld_pkg::OP_ROT;
        if (cnt_q == LAST_ITER) begin
          cnt_d   = '0;
          state_d = ST_SAVEP;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_SAVEP: begin
        cmd_o.op = mld_pkg::OP_SAVEP;
        state_d  = ST_MULC;
      end
      ST_MULC: begin
        cmd_o.op = mld_pkg::OP_MULC;
        state_d  = ST_MULS;
      end
      ST_MULS: begin
        cmd_o.op = mld_pkg::OP_MULS;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        // wait until the output register is free
        if (!oval_q || out_ready_i) begin
          cmd_o.op = mld_pkg::OP_OUT;
          oval_d   = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      oval_q  <= oval_d;
    end
  end

endmodule

`default_nettype wire

@@ design/mld_dp.sv @@
// datapath: deltas, angle update, yaw wrap, shared cordic unit and output rounding
`timescale 1ns / 1ps
`default_nettype none

module mld_dp #(
  parameter int ANGLE_FRAC_BITS = mld_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mld_pkg::mld_cmd_t  cmd_i,
  input  wire logic signed [15:0] pos_x_i,
  input  wire logic signed [15:0] pos_y_i,
  input  wire logic [15:0]        sensitivity_i,
  input  wire logic [6:0]         pitch_limit_i,
  output logic signed [15:0]      dir_x_o,
  output logic signed [15:0]      dir_y_o,
  output logic signed [15:0]      dir_z_o
);

  localparam int F   = ANGLE_FRAC_BITS;
  localparam int FUP = (F > 16) ? F - 16 : 0;
  localparam int FDN = (F < 16) ? 16 - F : 0;
  localparam int YW  = 9 + F;           // yaw, unsigned, below 360 degrees
  localparam int PW  = 8 + F;           // pitch, signed, within 89 degrees
  localparam int DXW = 34 + FUP;        // scaled delta
  localparam int SW  = DXW + 1;         // angle sums
  localparam int EW  = YW + FDN + 1;    // angle before conversion to Q.16
  localparam int ZW  = 27;              // degrees Q.16 for the cordic
  localparam int MW  = 18;              // integer degrees during the wrap

  localparam logic signed [ZW-1:0] DEG90  = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);
  localparam logic signed [ZW-1:0] DEG360 = ZW'(360 * 65536);
  localparam logic signed [31:0]   GAIN   = 32'sd652032874;
  localparam logic [MW-1:0]        MOD_BIAS = MW'(92160);  // 360 * 256
  localparam logic [MW-1:0]        DEG_FULL = MW'(360);

  // architectural state
  logic signed [15:0]   last_x_q, last_y_q;
  logic                 first_q;
  logic [YW-1:0]        yaw_q;
  logic signed [PW-1:0] pitch_q;

  // working registers
  logic signed [16:0]   dpx_q, dpy_q;
  logic signed [33:0]   mprod_q;
  logic [MW-1:0]        ymod_q;
  logic [F-1:0]         yfrac_q;
  logic signed [31:0]   x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic                 neg_q;
  logic signed [31:0]   cy_q, sy_q, cp_q, sp_q;
  logic signed [63:0]   cprod_q;
  logic signed [15:0]   rx_q;
  logic signed [15:0]   dir_x_q, dir_y_q, dir_z_q;

  logic signed [16:0]   dsel;
  logic signed [33:0]   mprod_w;
  logic signed [DXW-1:0] mp_w, dd_w;
  logic signed [SW-1:0] yaw_sum, pitch_sum, lim_w, plim_w;
  logic [6:0]           limc;
  logic [MW-1:0]        ymod_w, mod_c, ymod_nx;
  logic signed [EW-1:0] yaw_e, pitch_e;
  logic signed [ZW-1:0] yaw16, pitch16, ang, fold_a, fold_z;
  logic                 fold_neg;
  logic signed [31:0]   xs, ys, xr, yr, x_fin, y_fin;
  logic signed [ZW-1:0] at_w, zr;
  logic signed [31:0]   csel;
  logic signed [63:0]   cprod_w;

  function automatic logic signed [15:0] sat16(input logic signed [33:0] r);
    logic signed [15:0] s;
    if (r > 34'sd32767) begin
      s = 16'sh7fff;
    end else if (r < -34'sd32768) begin
      s = 16'sh8000;
    end else begin
      s = r[15:0];
    end
    return s;
  endfunction

  // shared delta multiplier
  always_comb begin
    dsel    = (cmd_i.op == mld_pkg::OP_MULX) ? dpx_q : dpy_q;
    mprod_w = dsel * $signed({1'b0, sensitivity_i});
    mp_w    = DXW'(mprod_q);
    dd_w    = (mp_w <<< FUP) >>> FDN;
  end

  // yaw sum split into integer degrees (biased positive) and fraction
  always_comb begin
    yaw_sum = $signed({{(SW-YW){1'b0}}, yaw_q}) + SW'(dd_w);
    ymod_w  = MW'((yaw_sum >>> F) + SW'(MOD_BIAS));
  end

  // pitch sum and clamp
  always_comb begin
    limc      = (pitch_limit_i > mld_pkg::PLIM_MAX) ? mld_pkg::PLIM_MAX : pitch_limit_i;
    lim_w     = $signed(SW'(limc) << F);
    pitch_sum = SW'(pitch_q) + SW'(dd_w);
    if (pitch_sum > lim_w) begin
      plim_w = lim_w;
    end else if (pitch_sum < -lim_w) begin
      plim_w = -lim_w;
    end else begin
      plim_w = pitch_sum;
    end
  end

  // one restoring step of the modulo 360 wrap
  always_comb begin
    mod_c   = DEG_FULL << cmd_i.idx;
    ymod_nx = (ymod_q >= mod_c) ? ymod_q - mod_c : ymod_q;
  end

  // angles to degrees Q.16 and fold into the cordic range
  always_comb begin
    yaw_e   = $signed({{(EW-YW){1'b0}}, yaw_q});
    pitch_e = EW'(pitch_q);
    yaw16   = ZW'((yaw_e <<< FDN) >>> FUP);
    pitch16 = ZW'((pitch_e <<< FDN) >>> FUP);
    ang     = (cmd_i.op == mld_pkg::OP_ZYAW) ? yaw16 : pitch16;
    fold_a  = (ang > DEG180) ? ang - DEG360 : ang;
    fold_neg = 1'b0;
    fold_z   = fold_a;
    if (fold_a > DEG90) begin
      fold_z   = fold_a - DEG180;
      fold_neg = 1'b1;
    end else if (fold_a < -DEG90) begin
      fold_z   = fold_a + DEG180;
      fold_neg = 1'b1;
    end
  end

  // one cordic rotation step
  always_comb begin
    xs   = y_q >>> cmd_i.idx;
    ys   = x_q >>> cmd_i.idx;
    at_w = ZW'(mld_pkg::atan_q16(cmd_i.idx));
    if (z_q >= 0) begin
      xr = x_q - xs;
      yr = y_q + ys;
      zr = z_q - at_w;
    end else begin
      xr = x_q + xs;
      yr = y_q - ys;
      zr = z_q + at_w;
    end
    x_fin = neg_q ? -x_q : x_q;
    y_fin = neg_q ? -y_q : y_q;
  end

  // shared product multiplier for the x and z components
  always_comb begin
    csel    = (cmd_i.op == mld_pkg::OP_MULC) ? cy_q : sy_q;
    cprod_w = csel * cp_q;
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q <= 16'sd400;
      last_y_q <= 16'sd300;
      first_q  <= 1'b1;
      yaw_q    <= YW'(270) << F;
      pitch_q  <= '0;
    end else begin
      case (cmd_i.op)
        mld_pkg::OP_LOAD: begin
          last_x_q <= pos_x_i;
          last_y_q <= pos_y_i;
          first_q  <= 1'b0;
        end
        mld_pkg::OP_PITCH: begin
          pitch_q <= PW'(plim_w);
        end
        mld_pkg::OP_MOD: begin
          if (cmd_i.idx == '0) begin
            yaw_q <= {ymod_nx[8:0], yfrac_q};
          end
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      mld_pkg::OP_LOAD: begin
        if (first_q) begin
          dpx_q <= '0;
          dpy_q <= '0;
        end else begin
          dpx_q <= 17'(pos_x_i) - 17'(last_x_q);
          dpy_q <= 17'(last_y_q) - 17'(pos_y_i);
        end
      end
      mld_pkg::OP_MULX: begin
        mprod_q <= mprod_w;
      end
      mld_pkg::OP_YAW: begin
        yfrac_q <= yaw_sum[F-1:0];
        ymod_q  <= ymod_w;
        mprod_q <= mprod_w;
      end
      mld_pkg::OP_MOD: begin
        ymod_q <= ymod_nx;
      end
      mld_pkg::OP_ZYAW: begin
        x_q   <= GAIN;
        y_q   <= '0;
        z_q   <= fold_z;
        neg_q <= fold_neg;
      end
      mld_pkg::OP_ROT: begin
        x_q <= xr;
        y_q <= yr;
        z_q <= zr;
      end
      mld_pkg::OP_ZPITCH: begin
        cy_q  <= x_fin;
        sy_q  <= y_fin;
        x_q   <= GAIN;
        y_q   <= '0;
        z_q   <= fold_z;
        neg_q <= fold_neg;
      end
      mld_pkg::OP_SAVEP: begin
        cp_q <= x_fin;
        sp_q <= y_fin;
      end
      mld_pkg::OP_MULC: begin
        cprod_q <= cprod_w;
      end
      mld_pkg::OP_MULS: begin
        rx_q    <= sat16(34'((cprod_q + 64'sd17592186044416) >>> 45));
        cprod_q <= cprod_w;
      end
      mld_pkg::OP_OUT: begin
        dir_x_q <= rx_q;
        dir_y_q <= sat16(34'((34'(sp_q) + 34'sd16384) >>> 15));
        dir_z_q <= sat16(34'((cprod_q + 64'sd17592186044416) >>> 45));
      end
      default: begin
      end
    endcase
  end

  assign dir_x_o = dir_x_q;
  assign dir_y_o = dir_y_q;
  assign dir_z_o = dir_z_q;

endmodule

`default_nettype wire

@@ design/mouse_look_direction.sv @@
// top level: mouse-look direction vector from cursor positions
//
//   channel  | side   | payload                              | handshake
//   s_axis   | in     | tdata[31:0]: pos_x, pos_y            | tvalid/tready
//   m_axis   | out    | tdata[47:0]: dir_x, dir_y, dir_z     | tvalid/tready
//   apb      | config | 0x0 sensitivity, 0x4 pitch_limit     | psel/penable, pready=1
//
// an item runs from the input transfer to the result in the output register
// through the single shared cordic unit, one rotation per cycle for yaw then
// pitch. the yaw wrap adds nine conditional-subtract steps; the next input
// transfer can follow in the cycle after the result is loaded.
// the next input is taken while a result still waits on m_axis; a stalled
// output holds the sequencer only at its final step. reset is asynchronous.
`timescale 1ns / 1ps
`default_nettype none

module mouse_look_direction #(
  parameter int CORDIC_ITERATIONS = mld_pkg::DEF_CORDIC_ITERATIONS,
  parameter int ANGLE_FRAC_BITS   = mld_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [15:0] pos_x, [31:16] pos_y
  // output stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,   // [15:0] dir_x, [31:16] dir_y, [47:32] dir_z
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0]        sens_q;
  logic [6:0]         plim_q;
  logic               cfg_wr;
  mld_pkg::mld_cmd_t  cmd;
  logic signed [15:0] dir_x, dir_y, dir_z;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q <= mld_pkg::SENS_RESET;
      plim_q <= mld_pkg::PLIM_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == mld_pkg::ADDR_PLIM[2]) begin
        plim_q <= pwdata[6:0];
      end else begin
        sens_q <= pwdata[15:0];
      end
    end
  end

  // register read
  always_comb begin
    if (paddr[2] == mld_pkg::ADDR_SENS[2]) begin
      prdata = {16'd0, sens_q};
    end else begin
      prdata = {25'd0, plim_q};
    end
  end

  // controller
  mld_ctrl #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  // datapath
  mld_dp #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .pos_x_i       (s_axis_tdata_i[15:0]),
    .pos_y_i       (s_axis_tdata_i[31:16]),
    .sensitivity_i (sens_q),
    .pitch_limit_i (plim_q),
    .dir_x_o       (dir_x),
    .dir_y_o       (dir_y),
    .dir_z_o       (dir_z)
  );

  assign m_axis_tdata_o = {dir_z, dir_y, dir_x};

endmodule

`default_nettype wire

@@ sim/mouse_look_direction_tb.sv @@
// self-checking testbench for the mouse-look direction block: directed table, then random cursor moves
`timescale 1ns / 1ps

module mouse_look_direction_tb;

  // build values of the block under test
  localparam int ANG_FRAC   = mld_pkg::DEF_ANGLE_FRAC_BITS;
  localparam int ROT_STEPS  = (mld_pkg::DEF_CORDIC_ITERATIONS > mld_pkg::MAX_ITERATIONS) ?
                              mld_pkg::MAX_ITERATIONS : mld_pkg::DEF_CORDIC_ITERATIONS;
  localparam longint DEG    = 64'sd65536;
  localparam longint GAIN_Q30 = 64'sd652032874;

  // run control
  localparam int SETTLE_CYCLES = 19 + 2 * mld_pkg::MAX_ITERATIONS + 9 + 20;
  localparam int IDLE_LIMIT    = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 450;
  localparam int RAND_PHASES   = 9;
  localparam int PHASE_ITEMS   = 100;
  localparam int PRINT_LIMIT   = 20;

  typedef struct packed {
    logic signed [15:0] dir_z;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_x;
  } dir_t;

  typedef enum logic [1:0] {ROW_POS, ROW_SENS, ROW_PLIM} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    int                 a;
    int                 b;
    bit                 typed;
    logic signed [15:0] typed_x;
  } stim_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_COMB, RX_TRICKLE} rx_mode_e;

  // atan(2^-i) in degrees, Q.16
  longint atan_deg [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // directed plan: extremes, first event, register corner values
  localparam int PLAN_LEN = 25;
  stim_row_t plan [PLAN_LEN] = '{
    '{ROW_SENS, 61440, 0, 1'b0, 16'sd0},
    '{ROW_POS, 0, 0, 1'b0, 16'sd0},          // first event, zero deltas
    '{ROW_POS, 96, 0, 1'b1, 16'sd32767},     // yaw 270 + 90 wraps to 0, +1 saturates
    '{ROW_POS, 96, 0, 1'b0, 16'sd0},
    '{ROW_POS, 32767, -32768, 1'b0, 16'sd0},
    '{ROW_POS, -32768, 32767, 1'b0, 16'sd0},
    '{ROW_SENS, 65535, 0, 1'b0, 16'sd0},
    '{ROW_POS, 32767, 32767, 1'b0, 16'sd0},
    '{ROW_POS, -32768, -32768, 1'b0, 16'sd0},
    '{ROW_SENS, 0, 0, 1'b0, 16'sd0},
    '{ROW_POS, 1234, -4321, 1'b0, 16'sd0},
    '{ROW_POS, -32768, 32767, 1'b0, 16'sd0},
    '{ROW_SENS, 13107, 0, 1'b0, 16'sd0},
    '{ROW_PLIM, 0, 0, 1'b0, 16'sd0},
    '{ROW_POS, 0, -20000, 1'b0, 16'sd0},     // pitch pinned at zero
    '{ROW_POS, 100, 20000, 1'b0, 16'sd0},
    '{ROW_PLIM, 127, 0, 1'b0, 16'sd0},       // limit above 89 acts as 89
    '{ROW_POS, 0, -32768, 1'b0, 16'sd0},
    '{ROW_POS, 0, 32767, 1'b0, 16'sd0},
    '{ROW_PLIM, 89, 0, 1'b0, 16'sd0},
    '{ROW_SENS, 1, 0, 1'b0, 16'sd0},
    '{ROW_POS, 1, 32766, 1'b0, 16'sd0},
    '{ROW_POS, 0, 32767, 1'b0, 16'sd0},
    '{ROW_PLIM, 45, 0, 1'b0, 16'sd0},
    '{ROW_POS, -500, 0, 1'b0, 16'sd0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [31:0] s_data = '0;            // [15:0] pos_x, [31:16] pos_y
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [47:0] m_data;                 // [15:0] dir_x, [31:16] dir_y, [47:32] dir_z
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state and register copies
  longint look_sens = 13107;
  int     look_plim = 89;
  longint prev_x = 400;
  longint prev_y = 300;
  bit     awaiting_first = 1'b1;
  longint yaw_fx = 64'sd270 <<< ANG_FRAC;
  longint pitch_fx = 0;

  dir_t   pending_dirs [$];
  int     errors = 0;
  int     pos_count = 0;
  int     dir_count = 0;
  int     reg_writes = 0;
  int     idle_cycles = 0;
  int     burst_left = 0;
  int     sent_x = 0;
  int     sent_y = 0;

  // receiver stall pattern state
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_tick = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;

  always #1 clk_i = ~clk_i;

  mouse_look_direction u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // fixed-point helpers for the direction predictor
  function automatic longint to_frac(input longint v, input int from, input int to);
    if (to >= from) return v <<< (to - from);
    return v >>> (from - to);
  endfunction

  function automatic logic [15:0] to_q15(input longint v, input int sh);
    longint r;
    r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // rotation-mode cordic, angle in degrees Q.16 within [-90, 90], results Q2.30
  function automatic void cordic_rotate(input longint ang, output longint c,
                                        output longint s);
    longint x, y, z, dx, dy;
    x = GAIN_Q30;
    y = 0;
    z = ang;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_deg[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_deg[i];
      end
    end
    c = x;
    s = y;
  endfunction

  // fold into [-90, 90] degrees, flip the sign where folding needs it
  function automatic void folded_sin_cos(input longint a, output longint c,
                                         output longint s);
    bit flip;
    flip = 1'b0;
    if (a > 180 * DEG) a = a - 360 * DEG;
    if (a > 90 * DEG) begin
      a = a - 180 * DEG; flip = 1'b1;
    end else if (a < -90 * DEG) begin
      a = a + 180 * DEG; flip = 1'b1;
    end
    cordic_rotate(a, c, s);
    if (flip) begin
      c = -c; s = -s;
    end
  endfunction

  // advance yaw and pitch by one cursor position and form the direction vector
  function automatic dir_t advance_look(input logic signed [15:0] px16,
                                        input logic signed [15:0] py16);
    longint px, py, dx, dy, lim, full, cy, sy, cp, sp;
    dir_t   d;
    px = px16;
    py = py16;
    full = 64'sd360 <<< ANG_FRAC;
    if (awaiting_first) begin
      prev_x = px;
      prev_y = py;
      awaiting_first = 1'b0;
    end
    dx = to_frac((px - prev_x) * look_sens, 16, ANG_FRAC);
    dy = to_frac((prev_y - py) * look_sens, 16, ANG_FRAC);
    prev_x = px;
    prev_y = py;

    // yaw wraps exactly modulo a full turn
    yaw_fx = (yaw_fx + dx) % full;
    if (yaw_fx < 0) yaw_fx = yaw_fx + full;

    // pitch clamps to the limit, at most 89 degrees
    lim = longint'((look_plim > 89) ? 89 : look_plim) <<< ANG_FRAC;
    pitch_fx = pitch_fx + dy;
    if (pitch_fx > lim) pitch_fx = lim;
    if (pitch_fx < -lim) pitch_fx = -lim;

    folded_sin_cos(to_frac(yaw_fx, ANG_FRAC, 16), cy, sy);
    folded_sin_cos(to_frac(pitch_fx, ANG_FRAC, 16), cp, sp);
    d.dir_x = to_q15(cy * cp, 45);
    d.dir_y = to_q15(sp, 15);
    d.dir_z = to_q15(sy * cp, 45);
    return d;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // offer one cursor position in bursts with random gaps, predict on transfer
  task automatic push_pos(input int x, input int y, input bit typed,
                          input logic signed [15:0] typed_x);
    int   gap;
    dir_t want;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_valid <= 1'b1;
    s_data  <= {y[15:0], x[15:0]};
    do @(posedge clk_i); while (!s_ready);
    want = advance_look(x[15:0], y[15:0]);
    if (typed) want.dir_x = typed_x;
    pending_dirs.push_back(want);
    pos_count++;
    burst_left--;
    sent_x = $signed(x[15:0]);
    sent_y = $signed(y[15:0]);
  endtask

  // stop offering and let every pending result come out
  task automatic settle_block();
    s_valid <= 1'b0;
    burst_left = 0;
    while (pending_dirs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb write: setup cycle then access cycle
  task automatic write_reg(input logic [2:0] addr, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == mld_pkg::ADDR_SENS) look_sens = value & 32'hFFFF;
    else if (addr == mld_pkg::ADDR_PLIM) look_plim = value & 32'h7F;
    reg_writes++;
  endtask

  // receiver: changing stall patterns plus one long hold-off
  always @(posedge clk_i) begin
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else if (!hold_done && pos_count >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(40, 300);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN:  m_ready <= 1'b1;
        RX_COIN:  m_ready <= $urandom_range(0, 1);
        RX_COMB:  m_ready <= (rx_tick % 3) != 0;
        default:  m_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // result check against the oldest pending direction
  always @(posedge clk_i) begin
    dir_t got, want;
    if (rst_ni && m_valid && m_ready) begin
      got = m_data;
      dir_count++;
      if (pending_dirs.size() == 0) begin
        report_mismatch("result with none pending, dir_x", 0, got.dir_x);
      end else begin
        want = pending_dirs.pop_front();
        if (got.dir_x !== want.dir_x) report_mismatch("dir_x", want.dir_x, got.dir_x);
        if (got.dir_y !== want.dir_y) report_mismatch("dir_y", want.dir_y, got.dir_y);
        if (got.dir_z !== want.dir_z) report_mismatch("dir_z", want.dir_z, got.dir_z);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] timeout: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
      $display("mouse_look_direction verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // main sequence
  initial begin
    int x, y, pick, sens_val, plim_val;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int r = 0; r < PLAN_LEN; r++) begin
      case (plan[r].kind)
        ROW_POS:  push_pos(plan[r].a, plan[r].b, plan[r].typed, plan[r].typed_x);
        ROW_SENS: begin
          settle_block();
          write_reg(mld_pkg::ADDR_SENS, plan[r].a);
        end
        default: begin
          settle_block();
          write_reg(mld_pkg::ADDR_PLIM, plan[r].a);
        end
      endcase
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle_block();
      pick = $urandom_range(0, 5);
      case (pick)
        0:       sens_val = 13107;
        1:       sens_val = 65535;
        2:       sens_val = $urandom_range(1, 255);
        default: sens_val = $urandom_range(0, 65535);
      endcase
      pick = $urandom_range(0, 5);
      case (pick)
        0:       plim_val = 89;
        1:       plim_val = 0;
        2:       plim_val = $urandom_range(90, 127);
        default: plim_val = $urandom_range(1, 89);
      endcase
      if (ph == 0) begin
        sens_val = 65535;
        plim_val = 89;
      end
      write_reg(mld_pkg::ADDR_SENS, sens_val);
      write_reg(mld_pkg::ADDR_PLIM, plim_val);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
          // ordinary cursor motion near the last position
          x = sent_x + $signed($urandom_range(0, 600)) - 300;
          y = sent_y + $signed($urandom_range(0, 600)) - 300;
        end else if (pick == 8) begin
          x = $urandom_range(0, 65535);
          y = $urandom_range(0, 65535);
        end else begin
          x = sent_x;
          y = sent_y;
        end
        push_pos(x, y, 1'b0, 16'sd0);
      end
    end

    // drain and final check
    settle_block();
    if (pending_dirs.size() != 0)
      report_mismatch("results missing at end", pending_dirs.size(), 0);
    $display("covered %0d cursor transfers, %0d direction results, %0d register writes",
             pos_count, dir_count, reg_writes);
    $display("sensitivity and pitch limit swept through extremes, one long output stall");
    if (errors == 0) begin
      $display("mouse_look_direction verification clean");
    end else begin
      $display("mouse_look_direction verification failed");
    end
    $finish;
  end

endmodule
